// File: design/lcar_pkg.sv
// Shared types and constants for the load-cell ADC reader with averaging.
// Used by load_cell_adc_reader_avg; depends on nothing else.
`timescale 1ns / 1ps

package lcar_pkg;

   // Number of readings summed before an average is published.
   localparam int unsigned AVG_COUNT = 10;

   // Converter word length and derived widths.
   localparam int unsigned DATA_BITS  = 24;
   localparam int unsigned SUM_BITS   = 28;
   localparam int unsigned PULSE_BITS = 5;
   localparam int unsigned COUNT_BITS = 4;

   // Reciprocal used to divide the sum magnitude by AVG_COUNT.
   localparam int unsigned RECIP_SHIFT = 31;
   localparam logic [31:0] AVG_RECIP   = 32'((64'd1 << RECIP_SHIFT) / AVG_COUNT);

   // Register map (word index).
   localparam logic [2:0] REG_HALF_PERIOD   = 3'd0;
   localparam logic [2:0] REG_GAIN_SELECT   = 3'd1;
   localparam logic [2:0] REG_READY_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_INIT_TIMEOUT  = 3'd3;
   localparam logic [2:0] REG_BACKOFF       = 3'd4;

   // Register reset values.
   localparam logic [15:0] HALF_PERIOD_RESET   = 16'd50;
   localparam logic [1:0]  GAIN_SELECT_RESET   = 2'd2;
   localparam logic [31:0] READY_TIMEOUT_RESET = 32'd25000000;
   localparam logic [31:0] INIT_TIMEOUT_RESET  = 32'd10000000;
   localparam logic [31:0] BACKOFF_RESET       = 32'd25000000;

   typedef enum logic [1:0] {
      MODE_INIT,
      MODE_WAIT,
      MODE_READ,
      MODE_ERROR
   } mode_type;

endpackage

// File: design/load_cell_adc_reader_avg.sv
// Serial reader for a 24-bit load-cell ADC with an average over AVG_COUNT readings.
// Each result word is registered from its accepted tick word.
// Throughput: one tick word per cycle; the result register lets a new word in while
// the last result waits, and the input stalls only when that register is full and stalled.
// Reset (synchronous, active high) clears control state and loads register defaults.
// Uses lcar_pkg for the register map, defaults and the state type.
`timescale 1ns / 1ps

module load_cell_adc_reader_avg
   import lcar_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // Tick words: one sampled level of the ADC data line each.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_dout_level,
   // Result words: one per tick word.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_sck_level,
   output logic                        rsp_sample_valid,
   output logic signed [DATA_BITS-1:0] rsp_sample_value,
   output logic                        rsp_average_valid,
   output logic signed [DATA_BITS-1:0] rsp_average_value,
   output logic                        rsp_fault,
   output logic                        rsp_init_done,
   // Register port.
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [4:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers. Writes take effect at once; the block is
   // expected to be idle when they happen.
   // ------------------------------------------------------------------
   logic [15:0] half_period_ff;
   logic [1:0]  gain_select_ff;
   logic [31:0] ready_timeout_ff;
   logic [31:0] init_timeout_ff;
   logic [31:0] backoff_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= HALF_PERIOD_RESET;
         gain_select_ff   <= GAIN_SELECT_RESET;
         ready_timeout_ff <= READY_TIMEOUT_RESET;
         init_timeout_ff  <= INIT_TIMEOUT_RESET;
         backoff_ff       <= BACKOFF_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_HALF_PERIOD:   half_period_ff   <= csr_pwdata[15:0];
            REG_GAIN_SELECT:   gain_select_ff   <= csr_pwdata[1:0];
            REG_READY_TIMEOUT: ready_timeout_ff <= csr_pwdata;
            REG_INIT_TIMEOUT:  init_timeout_ff  <= csr_pwdata;
            REG_BACKOFF:       backoff_ff       <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HALF_PERIOD:   csr_prdata = {16'd0, half_period_ff};
         REG_GAIN_SELECT:   csr_prdata = {30'd0, gain_select_ff};
         REG_READY_TIMEOUT: csr_prdata = ready_timeout_ff;
         REG_INIT_TIMEOUT:  csr_prdata = init_timeout_ff;
         REG_BACKOFF:       csr_prdata = backoff_ff;
         default:           csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake. The result register is refilled on every accepted tick;
   // the input stalls only while that register holds a word nobody takes.
   // ------------------------------------------------------------------
   logic rsp_valid_ff;
   logic accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Reader state.
   // ------------------------------------------------------------------
   mode_type                    mode_ff, mode_in;
   logic [31:0]                 tick_count_ff, tick_count_in;
   logic [PULSE_BITS-1:0]       pulse_index_ff, pulse_index_in;
   logic                        clock_out_ff, clock_out_in;
   logic [DATA_BITS-1:0]        shift_word_ff, shift_word_in;
   logic signed [DATA_BITS-1:0] last_reading_ff, last_reading_in;
   logic signed [SUM_BITS-1:0]  running_sum_ff, running_sum_in;
   logic [COUNT_BITS-1:0]       sum_count_ff, sum_count_in;
   logic signed [DATA_BITS-1:0] average_hold_ff, average_hold_in;
   logic                        started_ff, started_in;
   logic                        sample_valid_in;
   logic                        average_valid_in;

   // Quotient of the current sum, kept up to date by a short pipeline.
   logic signed [DATA_BITS-1:0] quot_ff;

   logic [31:0]           tick_next;
   logic [31:0]           wait_limit;
   logic [PULSE_BITS-1:0] pulse_total;
   logic [PULSE_BITS-1:0] pulse_next;

   assign tick_next   = tick_count_ff + 32'd1;
   assign wait_limit  = (mode_ff == MODE_INIT) ? init_timeout_ff : ready_timeout_ff;
   assign pulse_total = PULSE_BITS'(DATA_BITS) + PULSE_BITS'(gain_select_ff)
                      + PULSE_BITS'(1);
   assign pulse_next  = pulse_index_ff + PULSE_BITS'(1);

   always_comb begin
      mode_in          = mode_ff;
      tick_count_in    = tick_count_ff;
      pulse_index_in   = pulse_index_ff;
      clock_out_in     = clock_out_ff;
      shift_word_in    = shift_word_ff;
      last_reading_in  = last_reading_ff;
      running_sum_in   = running_sum_ff;
      sum_count_in     = sum_count_ff;
      average_hold_in  = average_hold_ff;
      started_in       = started_ff;
      sample_valid_in  = 1'b0;
      average_valid_in = 1'b0;

      case (mode_ff)
         MODE_INIT, MODE_WAIT: begin
            clock_out_in = 1'b0;
            if (!req_dout_level) begin
               // Data line low: conversion ready, start the first high phase.
               mode_in        = MODE_READ;
               clock_out_in   = 1'b1;
               tick_count_in  = 32'd1;
               pulse_index_in = '0;
               shift_word_in  = '0;
            end else if (tick_next >= wait_limit) begin
               // Timed out. During start-up the wait simply restarts.
               tick_count_in = 32'd0;
               if (mode_ff == MODE_WAIT) begin
                  mode_in = MODE_ERROR;
               end
            end else begin
               tick_count_in = tick_next;
            end
         end
         MODE_READ: begin
            if (tick_count_ff >= {16'd0, half_period_ff}) begin
               tick_count_in = 32'd1;
               if (clock_out_ff) begin
                  // End of a high phase: the clock falls and a data bit is taken.
                  if (pulse_index_ff < PULSE_BITS'(DATA_BITS)) begin
                     shift_word_in = {shift_word_ff[DATA_BITS-2:0], req_dout_level};
                  end
                  clock_out_in = 1'b0;
               end else begin
                  pulse_index_in = pulse_next;
                  if (pulse_next >= pulse_total) begin
                     // Data and gain pulses are done; go back to the ready wait.
                     mode_in        = MODE_WAIT;
                     tick_count_in  = 32'd0;
                     pulse_index_in = '0;
                     if (!started_ff) begin
                        // The first read after reset only finishes start-up.
                        started_in = 1'b1;
                     end else begin
                        last_reading_in = $signed(shift_word_ff);
                        sample_valid_in = 1'b1;
                        if (sum_count_ff < COUNT_BITS'(AVG_COUNT)) begin
                           running_sum_in = running_sum_ff
                                          + SUM_BITS'($signed(shift_word_ff));
                           sum_count_in   = sum_count_ff + COUNT_BITS'(1);
                        end else begin
                           // This reading publishes the average instead of adding in.
                           average_hold_in  = quot_ff;
                           running_sum_in   = '0;
                           sum_count_in     = '0;
                           average_valid_in = 1'b1;
                        end
                     end
                  end else begin
                     clock_out_in = 1'b1;
                  end
               end
            end else begin
               tick_count_in = tick_next;
            end
         end
         MODE_ERROR: begin
            clock_out_in = 1'b0;
            if (tick_next >= backoff_ff) begin
               tick_count_in = 32'd0;
               mode_in       = MODE_WAIT;
            end else begin
               tick_count_in = tick_next;
            end
         end
         default: begin
            clock_out_in  = 1'b0;
            tick_count_in = 32'd0;
            mode_in       = MODE_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_INIT;
         tick_count_ff   <= 32'd0;
         pulse_index_ff  <= '0;
         clock_out_ff    <= 1'b0;
         shift_word_ff   <= '0;
         last_reading_ff <= '0;
         running_sum_ff  <= '0;
         sum_count_ff    <= '0;
         average_hold_ff <= '0;
         started_ff      <= 1'b0;
      end else if (accept) begin
         mode_ff         <= mode_in;
         tick_count_ff   <= tick_count_in;
         pulse_index_ff  <= pulse_index_in;
         clock_out_ff    <= clock_out_in;
         shift_word_ff   <= shift_word_in;
         last_reading_ff <= last_reading_in;
         running_sum_ff  <= running_sum_in;
         sum_count_ff    <= sum_count_in;
         average_hold_ff <= average_hold_in;
         started_ff      <= started_in;
      end
   end

   // ------------------------------------------------------------------
   // Average pipeline. The sum changes only when a read completes, and the
   // next publish comes at least one full read later, so the latency of the
   // mag, prod, q_fix and quot registers here is never visible. Division by
   // AVG_COUNT is done on the magnitude with a reciprocal multiply and one
   // correction step, then the sign is put back, which truncates toward zero.
   // ------------------------------------------------------------------
   logic [SUM_BITS-1:0]             mag_ff, mag2_ff;
   logic                            neg_ff, neg2_ff, neg3_ff;
   logic [SUM_BITS+31:0]            prod_ff;
   logic [SUM_BITS-1:0]             q_est;
   logic [SUM_BITS-1:0]             q_rem;
   logic [SUM_BITS-1:0]             q_fix_ff;

   assign q_est = prod_ff[SUM_BITS+RECIP_SHIFT-1:RECIP_SHIFT];
   assign q_rem = mag2_ff - SUM_BITS'(q_est * SUM_BITS'(AVG_COUNT));

   always_ff @(posedge clock) begin
      neg_ff   <= running_sum_ff[SUM_BITS-1];
      mag_ff   <= running_sum_ff[SUM_BITS-1] ? SUM_BITS'(-running_sum_ff)
                                             : SUM_BITS'(running_sum_ff);
      prod_ff  <= (SUM_BITS+32)'(mag_ff) * (SUM_BITS+32)'(AVG_RECIP);
      mag2_ff  <= mag_ff;
      neg2_ff  <= neg_ff;
      q_fix_ff <= (q_rem >= SUM_BITS'(AVG_COUNT)) ? q_est + SUM_BITS'(1) : q_est;
      neg3_ff  <= neg2_ff;
      quot_ff  <= neg3_ff ? DATA_BITS'(-q_fix_ff) : DATA_BITS'(q_fix_ff);
   end

   // ------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_sck_level     <= clock_out_in;
         rsp_sample_valid  <= sample_valid_in;
         rsp_sample_value  <= last_reading_in;
         rsp_average_valid <= average_valid_in;
         rsp_average_value <= average_hold_in;
         rsp_fault         <= (mode_in == MODE_ERROR);
         rsp_init_done     <= started_in;
      end
   end

endmodule
